### rtl/irsp_pkg.sv
// ----------------------------------------------------------------------------
// irsp_pkg: shared definitions of the interval region status painter
// Widths, status codes, command codes, walker and sequencer types, and the
// status update rule applied to one map position.
// ----------------------------------------------------------------------------
`default_nettype none

package irsp_pkg;

  // Sizing of the status map.
  localparam int NUM_SEQS    = 16;
  localparam int MAX_SEQ_LEN = 65536;
  localparam int POS_W       = $clog2(MAX_SEQ_LEN);
  localparam int SEQ_W       = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
  localparam int ADDR_W      = SEQ_W + POS_W;
  localparam int MAP_DEPTH   = NUM_SEQS << POS_W;
  localparam int LEN_W       = $clog2(MAX_SEQ_LEN + 1);

  // Fixed field widths.
  localparam int CMD_W    = 2;
  localparam int SIDX_W   = 4;
  localparam int COORD_W  = 32;
  localparam int SLEN_W   = 17;
  localparam int CNT_W    = 17;
  localparam int NTOT_W   = 32;
  localparam int BUF_W    = 16;
  localparam int CODE_W   = 3;

  localparam logic [BUF_W-1:0]  BUF_RESET = BUF_W'(100);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [NTOT_W-1:0] NTOT_MAX  = '1;

  // Per-position status codes.
  localparam logic [CODE_W-1:0] CODE_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_TARGET   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_BUFFER   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_N        = 3'd3;
  localparam logic [CODE_W-1:0] CODE_TARGET_N = 3'd4;
  localparam logic [CODE_W-1:0] CODE_BUFFER_N = 3'd5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SET_LEN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TARGET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NREG    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT   = 2'd3;

  typedef enum logic [2:0] {
    WM_CLEAR,
    WM_TARGET,
    WM_FLANK,
    WM_NREG,
    WM_COUNT
  } walk_mode_t;

  typedef struct packed {
    logic              start;
    walk_mode_t        mode;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } walk_req_t;

  typedef struct packed {
    logic             busy;
    logic             step;
    logic             done;
    logic [CNT_W-1:0] tcount;
    logic [CNT_W-1:0] bcount;
  } walk_sts_t;

  typedef enum logic [3:0] {
    CS_CLEAR,
    CS_CLEAR_WAIT,
    CS_IDLE,
    CS_DECODE,
    CS_BODY,
    CS_BODY_WAIT,
    CS_LFLANK,
    CS_LFLANK_WAIT,
    CS_RFLANK,
    CS_RFLANK_WAIT,
    CS_NREG,
    CS_NREG_WAIT,
    CS_COUNT,
    CS_COUNT_WAIT,
    CS_RESULT
  } ctrl_state_t;

  // New status code of one position for a given walk.
  function automatic logic [CODE_W-1:0] next_code(walk_mode_t mode,
                                                  logic [CODE_W-1:0] old);
    logic [CODE_W-1:0] res;
    res = old;
    unique case (mode)
      WM_CLEAR:  res = CODE_NONE;
      WM_TARGET: res = (old == CODE_N) ? CODE_TARGET_N : CODE_TARGET;
      WM_FLANK: begin
        if (old == CODE_NONE) begin
          res = CODE_BUFFER;
        end else if (old == CODE_N) begin
          res = CODE_BUFFER_N;
        end
      end
      WM_NREG:   res = (old == CODE_TARGET) ? CODE_TARGET_N : CODE_N;
      WM_COUNT:  res = old;
      default:   res = old;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/irsp_in_if.sv
// ----------------------------------------------------------------------------
// irsp_in_if: command channel
// Valid/ready channel that carries one painter command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface irsp_in_if;
  import irsp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SIDX_W-1:0]  seq_index;
  logic [COORD_W-1:0] start_pos;
  logic [COORD_W-1:0] end_pos;
  logic [SLEN_W-1:0]  seq_length;

  modport source (output valid, cmd, seq_index, start_pos, end_pos, seq_length,
                  input ready);
  modport sink   (input valid, cmd, seq_index, start_pos, end_pos, seq_length,
                  output ready);
endinterface

`default_nettype wire

### rtl/irsp_out_if.sv
// ----------------------------------------------------------------------------
// irsp_out_if: result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface irsp_out_if;
  import irsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  target_bases;
  logic [CNT_W-1:0]  buffer_bases;
  logic [NTOT_W-1:0] n_bases_total;
  logic              seq_touched;

  modport source (output valid, target_bases, buffer_bases, n_bases_total,
                  seq_touched, input ready);
  modport sink   (input valid, target_bases, buffer_bases, n_bases_total,
                  seq_touched, output ready);
endinterface

`default_nettype wire

### rtl/irsp_ram.sv
// ----------------------------------------------------------------------------
// irsp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module irsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/irsp_walker.sv
// ----------------------------------------------------------------------------
// irsp_walker: shared read-modify-write unit over the status map
// Walks an address range one position per cycle, reads each code, applies
// the update rule and writes it back in the following cycle, or counts codes.
// ----------------------------------------------------------------------------
`default_nettype none

module irsp_walker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire irsp_pkg::walk_req_t       req,
  output irsp_pkg::walk_sts_t            sts,
  output logic                           ram_we,
  output logic [irsp_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [irsp_pkg::CODE_W-1:0]    ram_wdata,
  output logic                           ram_re,
  output logic [irsp_pkg::ADDR_W-1:0]    ram_raddr,
  input  wire logic [irsp_pkg::CODE_W-1:0] ram_rdata
);
  import irsp_pkg::*;

  logic              active_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] hi_r;
  walk_mode_t        mode_r;
  logic              wb_valid_r;
  logic              wb_last_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [CNT_W-1:0]  tcnt_r;
  logic [CNT_W-1:0]  bcnt_r;
  logic              is_tgt;
  logic              is_buf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      wb_valid_r <= 1'b0;
      wb_last_r  <= 1'b0;
    end else begin
      wb_valid_r <= active_r;
      wb_last_r  <= active_r && (addr_r == hi_r);
      if (req.start) begin
        active_r <= 1'b1;
      end else if (active_r && (addr_r == hi_r)) begin
        active_r <= 1'b0;
      end
    end
  end

  // Address and count datapath.
  always_ff @(posedge clk) begin
    wb_addr_r <= addr_r;
    if (req.start) begin
      addr_r <= req.lo;
      hi_r   <= req.hi;
      mode_r <= req.mode;
      tcnt_r <= '0;
      bcnt_r <= '0;
    end else begin
      if (active_r) begin
        addr_r <= addr_r + ADDR_W'(1);
      end
      if (wb_valid_r && (mode_r == WM_COUNT)) begin
        if (is_tgt && (tcnt_r != CNT_MAX)) begin
          tcnt_r <= tcnt_r + CNT_W'(1);
        end
        if (is_buf && (bcnt_r != CNT_MAX)) begin
          bcnt_r <= bcnt_r + CNT_W'(1);
        end
      end
    end
  end

  assign is_tgt = (ram_rdata == CODE_TARGET) || (ram_rdata == CODE_TARGET_N);
  assign is_buf = (ram_rdata == CODE_BUFFER) || (ram_rdata == CODE_BUFFER_N);

  assign ram_re    = active_r;
  assign ram_raddr = addr_r;
  assign ram_we    = wb_valid_r && (mode_r != WM_COUNT);
  assign ram_waddr = wb_addr_r;
  assign ram_wdata = next_code(mode_r, ram_rdata);

  always_comb begin
    sts.busy   = active_r || wb_valid_r;
    sts.step   = wb_valid_r;
    sts.done   = wb_valid_r && wb_last_r;
    sts.tcount = tcnt_r;
    sts.bcount = bcnt_r;
  end

endmodule

`default_nettype wire

### rtl/irsp_ctrl.sv
// ----------------------------------------------------------------------------
// irsp_ctrl: command sequencer of the painter
// Holds the length table, touched flags, N total and buffer size, clips each
// interval phase against the sequence length and drives the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module irsp_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  irsp_in_if.sink                        in_chan,
  irsp_out_if.source                     out_chan,
  input  wire logic                      cfg_wr_en,
  input  wire logic [irsp_pkg::BUF_W-1:0] cfg_wr_data,
  output irsp_pkg::walk_req_t            wk_req,
  input  wire irsp_pkg::walk_sts_t       wk_sts
);
  import irsp_pkg::*;

  localparam int W33 = COORD_W + 1;

  ctrl_state_t state_r, state_nxt;

  logic [BUF_W-1:0]   buf_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [SIDX_W-1:0]  seq_r;
  logic [COORD_W-1:0] start_r;
  logic [COORD_W-1:0] end_r;
  logic [SLEN_W-1:0]  newlen_r;
  logic [LEN_W-1:0]   len_r;
  logic               cnt_used_r;
  logic [NTOT_W-1:0]  ntot_r;
  logic [LEN_W-1:0]   len_tab_r [NUM_SEQS];
  logic [NUM_SEQS-1:0] touched_r;

  logic               out_valid_r;
  logic [CNT_W-1:0]   out_tgt_r;
  logic [CNT_W-1:0]   out_buf_r;
  logic [NTOT_W-1:0]  out_ntot_r;
  logic               out_touch_r;

  logic [SEQ_W-1:0]   idx;
  logic               seq_ok;
  logic [31:0]        newlen_sat;
  logic               out_load;

  // Shared clip unit inputs and outputs.
  logic               ph_en;
  logic [W33-1:0]     ph_lo;
  logic [W33-1:0]     ph_hi;
  logic [W33-1:0]     st33, en33, bf33, len33, lenm1;
  logic               clip_ok;
  logic [W33-1:0]     clip_hi;

  assign idx    = SEQ_W'(seq_r);
  assign seq_ok = (32'(seq_r) < NUM_SEQS);
  assign newlen_sat = (32'(newlen_r) > MAX_SEQ_LEN) ? 32'(MAX_SEQ_LEN) : 32'(newlen_r);

  assign st33  = W33'(start_r);
  assign en33  = W33'(end_r);
  assign bf33  = W33'(buf_r);
  assign len33 = W33'(len_r);
  assign lenm1 = len33 - W33'(1);

  // Interval bounds of the current phase, before clipping.
  always_comb begin
    ph_en = 1'b0;
    ph_lo = '0;
    ph_hi = '0;
    unique case (state_r)
      CS_BODY, CS_NREG: begin
        ph_en = 1'b1;
        ph_lo = st33;
        ph_hi = en33;
      end
      CS_LFLANK: begin
        ph_en = (start_r != '0);
        ph_lo = (st33 > bf33) ? (st33 - bf33) : '0;
        ph_hi = st33 - W33'(1);
      end
      CS_RFLANK: begin
        ph_en = (buf_r != '0);
        ph_lo = en33 + W33'(1);
        ph_hi = en33 + bf33;
      end
      CS_COUNT: begin
        ph_en = touched_r[idx];
        ph_lo = '0;
        ph_hi = lenm1;
      end
      default: begin
        ph_en = 1'b0;
      end
    endcase
  end

  assign clip_ok = ph_en && (len_r != '0) && (ph_lo <= ph_hi) && (ph_lo < len33);
  assign clip_hi = (ph_hi > lenm1) ? lenm1 : ph_hi;

  // Walker request and next state.
  always_comb begin
    state_nxt   = state_r;
    wk_req.start = 1'b0;
    wk_req.mode  = WM_CLEAR;
    wk_req.lo    = {idx, POS_W'(ph_lo)};
    wk_req.hi    = {idx, POS_W'(clip_hi)};
    unique case (state_r)
      CS_CLEAR: begin
        wk_req.start = 1'b1;
        wk_req.lo    = '0;
        wk_req.hi    = ADDR_W'(MAP_DEPTH - 1);
        state_nxt    = CS_CLEAR_WAIT;
      end
      CS_CLEAR_WAIT: if (wk_sts.done) state_nxt = CS_IDLE;
      CS_IDLE: if (in_chan.valid) state_nxt = CS_DECODE;
      CS_DECODE: begin
        if (!seq_ok) begin
          state_nxt = CS_RESULT;
        end else begin
          unique case (cmd_r)
            CMD_SET_LEN: state_nxt = CS_RESULT;
            CMD_TARGET:  state_nxt = CS_BODY;
            CMD_NREG:    state_nxt = CS_NREG;
            CMD_COUNT:   state_nxt = CS_COUNT;
            default:     state_nxt = CS_RESULT;
          endcase
        end
      end
      CS_BODY: begin
        wk_req.start = clip_ok;
        wk_req.mode  = WM_TARGET;
        state_nxt    = clip_ok ? CS_BODY_WAIT : CS_LFLANK;
      end
      CS_BODY_WAIT: if (wk_sts.done) state_nxt = CS_LFLANK;
      CS_LFLANK: begin
        wk_req.start = clip_ok;
        wk_req.mode  = WM_FLANK;
        state_nxt    = clip_ok ? CS_LFLANK_WAIT : CS_RFLANK;
      end
      CS_LFLANK_WAIT: if (wk_sts.done) state_nxt = CS_RFLANK;
      CS_RFLANK: begin
        wk_req.start = clip_ok;
        wk_req.mode  = WM_FLANK;
        state_nxt    = clip_ok ? CS_RFLANK_WAIT : CS_RESULT;
      end
      CS_RFLANK_WAIT: if (wk_sts.done) state_nxt = CS_RESULT;
      CS_NREG: begin
        wk_req.start = clip_ok;
        wk_req.mode  = WM_NREG;
        state_nxt    = clip_ok ? CS_NREG_WAIT : CS_RESULT;
      end
      CS_NREG_WAIT: if (wk_sts.done) state_nxt = CS_RESULT;
      CS_COUNT: begin
        wk_req.start = clip_ok;
        wk_req.mode  = WM_COUNT;
        state_nxt    = clip_ok ? CS_COUNT_WAIT : CS_RESULT;
      end
      CS_COUNT_WAIT: if (wk_sts.done) state_nxt = CS_RESULT;
      CS_RESULT: if (!out_valid_r || out_chan.ready) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_load = (state_r == CS_RESULT) && (!out_valid_r || out_chan.ready);

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= BUF_RESET;
      ntot_r      <= '0;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_used_r  <= 1'b0;
      for (int i = 0; i < NUM_SEQS; i++) begin
        len_tab_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        buf_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == CS_DECODE) begin
        cnt_used_r <= 1'b0;
        if (seq_ok) begin
          if (cmd_r == CMD_SET_LEN) begin
            len_tab_r[idx] <= LEN_W'(newlen_sat);
          end
          if ((cmd_r == CMD_TARGET) || (cmd_r == CMD_NREG)) begin
            touched_r[idx] <= 1'b1;
          end
        end
      end
      if ((state_r == CS_COUNT) && clip_ok) begin
        cnt_used_r <= 1'b1;
      end
      if ((state_r == CS_NREG_WAIT) && wk_sts.step && (ntot_r != NTOT_MAX)) begin
        ntot_r <= ntot_r + NTOT_W'(1);
      end
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk) begin
    if ((state_r == CS_IDLE) && in_chan.valid) begin
      cmd_r    <= in_chan.cmd;
      seq_r    <= in_chan.seq_index;
      start_r  <= in_chan.start_pos;
      end_r    <= in_chan.end_pos;
      newlen_r <= in_chan.seq_length;
    end
    if (state_r == CS_DECODE) begin
      len_r <= len_tab_r[idx];
    end
    if (out_load) begin
      out_tgt_r   <= cnt_used_r ? wk_sts.tcount : '0;
      out_buf_r   <= cnt_used_r ? wk_sts.bcount : '0;
      out_ntot_r  <= ntot_r;
      out_touch_r <= seq_ok && touched_r[idx];
    end
  end

  assign in_chan.ready          = (state_r == CS_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.target_bases  = out_tgt_r;
  assign out_chan.buffer_bases  = out_buf_r;
  assign out_chan.n_bases_total = out_ntot_r;
  assign out_chan.seq_touched   = out_touch_r;

endmodule

`default_nettype wire

### rtl/interval_region_status_painter_top.sv
// ----------------------------------------------------------------------------
// interval_region_status_painter_top: per-position region status painter
// Keeps a 3-bit status map per sequence and paints, counts and sizes it on
// command.
// ----------------------------------------------------------------------------
// Usage
//   in_chan carries one command per transfer: set a sequence length, paint a
//   target interval with buffer flanks, paint an N interval, or count the
//   target and buffer positions of a sequence. out_chan returns exactly one
//   result per command, in order. cfg_wr_en/cfg_wr_data set buffer_size.
// Throughput
//   The block takes one command at a time. A single walker moves through the
//   status RAM one position per cycle. A target paint walks its body and
//   both flanks (three ranges), an N paint one range, a count the whole
//   length of a touched sequence, and setting a length walks no range.
// Reset
//   rst_n clears the tables, the N total and buffer_size (back to 100), then
//   a clearing pass zeroes all 1,048,576 entries of the status RAM, one entry
//   per cycle, during which in_chan.ready stays low. Configuration writes are
//   taken throughout.
// Back-pressure
//   A result waits in the output register while out_chan.ready is low. The
//   next command may be taken meanwhile; its result waits until the register
//   is free.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_region_status_painter_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  irsp_in_if.sink                        in_chan,
  irsp_out_if.source                     out_chan,
  input  wire logic                      cfg_wr_en,
  input  wire logic [irsp_pkg::BUF_W-1:0] cfg_wr_data
);
  import irsp_pkg::*;

  walk_req_t         wk_req;
  walk_sts_t         wk_sts;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  // The sequencer owns all per-sequence tables and the channels.
  irsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wk_req      (wk_req),
    .wk_sts      (wk_sts)
  );

  // The walker is the one read-modify-write unit over the status map.
  irsp_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (wk_req),
    .sts       (wk_sts),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Status map: one 3-bit code per position of every sequence.
  irsp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A new command is taken only when no walk is in flight.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !wk_sts.busy)
    else $error("command accepted while the walker is busy");

  // The sequencer never restarts the walker in the middle of a walk.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wk_req.start |-> !wk_sts.busy)
    else $error("walker started while busy");

  // Every map write is the write-back of a read issued in the previous cycle.
  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> $past(ram_re))
    else $error("status map written without a preceding read");

endmodule

`default_nettype wire

### test/irsp_checker.sv
// ----------------------------------------------------------------------------
// irsp_checker: scoreboard for the interval region status painter
// Watches the command, result and configuration ports, keeps its own copy of
// the status map, lengths, touched flags and N total, and compares every
// result transfer against the oldest predicted tally.
// ----------------------------------------------------------------------------
`default_nettype none

module irsp_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  irsp_in_if                              cmd_mon,
  irsp_out_if                             res_mon,
  input  wire logic                       cfg_wr_en,
  input  wire logic [irsp_pkg::BUF_W-1:0] cfg_wr_data,
  output int unsigned                     fail_count,
  output int unsigned                     outstanding
);
  import irsp_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]  target_bases;
    logic [CNT_W-1:0]  buffer_bases;
    logic [NTOT_W-1:0] n_bases_total;
    logic              seq_touched;
  } tally_t;

  bit [CODE_W-1:0] status_map [MAP_DEPTH];
  bit [LEN_W-1:0]  seq_len [NUM_SEQS];
  bit              painted [NUM_SEQS];
  bit [NTOT_W-1:0] n_sum;
  bit [BUF_W-1:0]  flank_width;
  tally_t          expected_tallies [$];

  // Clips [lo, hi] to the positions that exist in a sequence of length len.
  function automatic bit clip_span(input longint unsigned lo, input longint unsigned hi,
                                   input longint unsigned len,
                                   output longint unsigned a, output longint unsigned b);
    a = 0;
    b = 0;
    if (len == 0 || lo > hi || lo >= len) return 1'b0;
    a = lo;
    b = (hi > len - 1) ? len - 1 : hi;
    return 1'b1;
  endfunction

  // Buffer flanks only mark empty positions and N positions.
  function automatic void paint_flank(input int unsigned base, input longint unsigned lo,
                                      input longint unsigned hi, input longint unsigned len);
    longint unsigned a, b, j;
    if (clip_span(lo, hi, len, a, b)) begin
      for (j = a; j <= b; j++) begin
        if (status_map[base + j] == CODE_NONE) begin
          status_map[base + j] = CODE_BUFFER;
        end else if (status_map[base + j] == CODE_N) begin
          status_map[base + j] = CODE_BUFFER_N;
        end
      end
    end
  endfunction

  // Applies one command to the local copy of the state and returns its tally.
  function automatic tally_t predict_tally(input logic [CMD_W-1:0] cmd, input int unsigned seq,
                                           input longint unsigned st, input longint unsigned en,
                                           input int unsigned new_len);
    tally_t          t;
    longint unsigned len, a, b, j, sum;
    int unsigned     base;
    t = '0;
    if (seq < NUM_SEQS) begin
      len  = seq_len[seq];
      base = seq * MAX_SEQ_LEN;
      case (cmd)
        CMD_SET_LEN: begin
          seq_len[seq] = (new_len > MAX_SEQ_LEN) ? LEN_W'(MAX_SEQ_LEN) : LEN_W'(new_len);
        end
        CMD_TARGET: begin
          painted[seq] = 1'b1;
          if (clip_span(st, en, len, a, b)) begin
            for (j = a; j <= b; j++) begin
              status_map[base + j] = (status_map[base + j] == CODE_N) ? CODE_TARGET_N
                                                                       : CODE_TARGET;
            end
          end
          // Flanks are computed in 64 bits, so neither side can wrap around.
          if (st > 0) paint_flank(base, (st > flank_width) ? st - flank_width : 0, st - 1, len);
          if (flank_width > 0) paint_flank(base, en + 1, en + flank_width, len);
        end
        CMD_NREG: begin
          painted[seq] = 1'b1;
          if (clip_span(st, en, len, a, b)) begin
            sum   = n_sum + (b - a + 1);
            n_sum = (sum > NTOT_MAX) ? NTOT_MAX : sum[NTOT_W-1:0];
            for (j = a; j <= b; j++) begin
              status_map[base + j] = (status_map[base + j] == CODE_TARGET) ? CODE_TARGET_N
                                                                            : CODE_N;
            end
          end
        end
        CMD_COUNT: begin
          if (painted[seq]) begin
            for (j = 0; j < len; j++) begin
              if ((status_map[base + j] == CODE_TARGET || status_map[base + j] == CODE_TARGET_N)
                  && t.target_bases != CNT_MAX) begin
                t.target_bases++;
              end
              if ((status_map[base + j] == CODE_BUFFER || status_map[base + j] == CODE_BUFFER_N)
                  && t.buffer_bases != CNT_MAX) begin
                t.buffer_bases++;
              end
            end
          end
        end
        default: ;
      endcase
      t.seq_touched = painted[seq];
    end
    t.n_bases_total = n_sum;
    return t;
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    tally_t want;
    int     s;
    if (!rst_n) begin
      for (s = 0; s < NUM_SEQS; s++) begin
        seq_len[s] = '0;
        painted[s] = 1'b0;
      end
      n_sum       = '0;
      flank_width = BUF_RESET;
      fail_count  = 0;
      expected_tallies.delete();
    end else begin
      if (cfg_wr_en) flank_width = cfg_wr_data;
      // A result always belongs to an earlier command, so it is retired before
      // the command accepted at the same edge is predicted.
      if (res_mon.valid && res_mon.ready) begin
        if (expected_tallies.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with no command outstanding", $time);
        end else begin
          want = expected_tallies.pop_front();
          check_field("target_bases", want.target_bases, res_mon.target_bases);
          check_field("buffer_bases", want.buffer_bases, res_mon.buffer_bases);
          check_field("n_bases_total", want.n_bases_total, res_mon.n_bases_total);
          check_field("seq_touched", want.seq_touched, res_mon.seq_touched);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_tallies.push_back(predict_tally(cmd_mon.cmd, cmd_mon.seq_index,
                                                 cmd_mon.start_pos, cmd_mon.end_pos,
                                                 cmd_mon.seq_length));
      end
    end
    outstanding = expected_tallies.size();
  end

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the interval region status painter
// Drives directed and random painter commands with random gaps and result
// stalls, changes the flank width between phases, and lets irsp_checker
// predict and compare every result. Prints the verdict at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import irsp_pkg::*;

  // The longest stretch without any transfer is the clearing pass after
  // reset, which zeroes all 1,048,576 map entries. A whole-sequence count
  // walks at most 65536 positions. The limit is several times the clearing pass.
  localparam int unsigned IDLE_LIMIT      = 4_500_000;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned NUM_PHASES      = 6;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en;
  logic [BUF_W-1:0] cfg_wr_data;

  irsp_in_if  in_chan ();
  irsp_out_if out_chan ();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned idle_cycles;

  // While calm is set, neither the command side nor the result side idles.
  bit          calm;

  // Lengths the stimulus has set, used only to aim positions near each
  // sequence's end.
  int unsigned len_hint [NUM_SEQS];

  interval_region_status_painter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  irsp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (in_chan),
    .res_mon     (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(17, 150);
  endfunction

  // Presents one command and returns at the edge where it is transferred.
  // The valid line is only lowered when a gap precedes the next command, so
  // back-to-back commands keep it high without a glitch.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int unsigned seq,
                          input logic [COORD_W-1:0] st, input logic [COORD_W-1:0] en,
                          input logic [SLEN_W-1:0] new_len);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= cmd;
    in_chan.seq_index  <= SIDX_W'(seq);
    in_chan.start_pos  <= st;
    in_chan.end_pos    <= en;
    in_chan.seq_length <= new_len;
    if (cmd == CMD_SET_LEN) len_hint[seq] = (new_len > MAX_SEQ_LEN) ? MAX_SEQ_LEN : new_len;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // One random command. Sequence 1 is the long one and is addressed rarely,
  // since each command there can walk up to 65536 positions. Most intervals
  // land in or just past the sequence; some are reversed (empty body) and
  // some are fully random 32-bit coordinates.
  task automatic random_item();
    int unsigned      seq, r, lim;
    logic [CMD_W-1:0] cmd;
    logic [31:0]      st, en;
    logic [SLEN_W-1:0] new_len;
    r   = $urandom_range(0, 14);
    seq = ($urandom_range(0, 99) == 0) ? 1 : ((r == 0) ? 0 : r + 1);
    r   = $urandom_range(0, 99);
    cmd = (r < 10) ? CMD_SET_LEN : (r < 50) ? CMD_TARGET : (r < 75) ? CMD_NREG : CMD_COUNT;
    lim = len_hint[seq] + 30;
    r   = $urandom_range(0, 99);
    if (r < 80) begin
      st = $urandom_range(0, lim);
      en = st + $urandom_range(0, 80);
    end else if (r < 90) begin
      en = $urandom_range(0, lim);
      st = en + $urandom_range(1, 40);
    end else begin
      st = $urandom();
      en = $urandom();
    end
    new_len = (seq == 1) ? SLEN_W'($urandom_range(0, 131071)) : SLEN_W'($urandom_range(0, 400));
    send_cmd(cmd, seq, st, en, new_len);
  endtask

  // Result side: ready runs of random length broken by random stalls.
  initial begin : result_drain
    int unsigned stall;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run if nothing is transferred on either channel for
  // too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL interval_region_status_painter_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      phase, i, s;
    logic [BUF_W-1:0] width;
    in_chan.valid      <= 1'b0;
    in_chan.cmd        <= CMD_SET_LEN;
    in_chan.seq_index  <= '0;
    in_chan.start_pos  <= '0;
    in_chan.end_pos    <= '0;
    in_chan.seq_length <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset flank width of 100. The first command
    // waits out the clearing pass.
    send_cmd(CMD_COUNT, 0, 0, 0, 0);                       // count before any paint
    send_cmd(CMD_SET_LEN, 0, 0, 0, 300);
    send_cmd(CMD_TARGET, 0, 150, 160, 0);
    send_cmd(CMD_TARGET, 0, 20, 30, 0);                    // left flank clamps at zero
    send_cmd(CMD_NREG, 0, 100, 200, 0);                    // N over target and buffer
    send_cmd(CMD_TARGET, 0, 250, 299, 0);                  // right flank past the end
    send_cmd(CMD_TARGET, 0, 280, 270, 0);                  // empty body, flanks only
    send_cmd(CMD_NREG, 0, 290, 32'hFFFF_FFFF, 0);          // end clipped to the length
    send_cmd(CMD_TARGET, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0); // flank ends beyond 32 bits
    send_cmd(CMD_NREG, 0, 32'hFFFF_FFFF, 0, 0);            // empty N interval
    send_cmd(CMD_COUNT, 0, 0, 0, 0);
    send_cmd(CMD_SET_LEN, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100); // shrink the sequence
    send_cmd(CMD_COUNT, 0, 0, 0, 0);
    send_cmd(CMD_SET_LEN, 0, 0, 0, 300);                   // old paint shows up again
    send_cmd(CMD_COUNT, 0, 0, 0, 0);
    send_cmd(CMD_SET_LEN, 1, 0, 0, 17'h1FFFF);             // saturates to the maximum
    send_cmd(CMD_TARGET, 1, 65500, 65535, 0);
    send_cmd(CMD_NREG, 1, 0, 0, 0);
    send_cmd(CMD_COUNT, 1, 0, 0, 0);
    send_cmd(CMD_NREG, 2, 5, 9, 0);                        // touched, but length zero
    send_cmd(CMD_COUNT, 2, 0, 0, 0);
    send_cmd(CMD_SET_LEN, 15, 0, 0, 65536);                // exactly the maximum
    send_cmd(CMD_TARGET, 15, 0, 0, 0);
    send_cmd(CMD_COUNT, 15, 0, 0, 0);

    // Give every short sequence a small length before the random part.
    for (s = 0; s < NUM_SEQS; s++) begin
      if (s != 1) send_cmd(CMD_SET_LEN, s, $urandom(), $urandom(), SLEN_W'($urandom_range(1, 400)));
    end

    // Random phases. Between phases the block is drained and the flank width
    // is rewritten: zero, the maximum, one, and random values.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        case (phase)
          1:       width = '0;
          2:       width = '1;
          3:       width = BUF_W'(1);
          4:       width = BUF_W'($urandom_range(2, 300));
          default: width = BUF_W'($urandom_range(0, 65535));
        endcase
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
      end
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = (i >= 60 && i < 100);
        random_item();
      end
      calm = 1'b0;
    end

    // Drain: the checker logs each command at the edge of its transfer, so the
    // count of outstanding results is read only at later edges.
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS interval_region_status_painter_top");
    end else begin
      $display("FAIL interval_region_status_painter_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
